// ----- rtl/ffsa_pkg.sv -----
// Package: shared constants for the first-fit segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;
  localparam int MemSize     = 2048;
  localparam int MaxSegments = 64;
  localparam int SizeW       = 12;
  localparam int AddrW       = 11;
  localparam int StatusW     = 3;

  localparam logic [StatusW-1:0] ST_GRANTED = 3'd0;
  localparam logic [StatusW-1:0] ST_NOFIT   = 3'd1;
  localparam logic [StatusW-1:0] ST_FREED   = 3'd2;
  localparam logic [StatusW-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/ffsa_if.sv -----
// Interfaces: request and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface ffsa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ffsa_pkg::SizeW-1:0]  request_size;
  logic [ffsa_pkg::AddrW-1:0]  block_address;
  modport source (output valid, kind, request_size, block_address, input ready);
  modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

interface ffsa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffsa_pkg::StatusW-1:0] status;
  logic [ffsa_pkg::AddrW-1:0]   start_address;
  logic [ffsa_pkg::SizeW-1:0]   free_total;
  modport source (output valid, status, start_address, free_total, input ready);
  modport sink (input valid, status, start_address, free_total, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffsa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/first_fit_segment_allocator_top.sv -----
// Top level: first-fit segment allocator with hole coalescing.
//
// Usage: requests arrive as words on the in_ channel (kind, request_size,
// block_address); one result word per request leaves on the out_ channel
// (status, start_address, free_total). valid/ready on both sides; a word
// moves at a rising edge where both are high.
// The segment table sits in one RAM, each entry {in_use, length, start},
// with registered reads. The sequencer reads one entry a cycle while it scans.
// A scan visits the entries in order, then posts the result; a split or
// a merge then shifts the table tail, each entry moved being read, then
// written. A free that merges with both neighbors shifts the tail twice.
// One request at a time.
// Reset (synchronous, rst_n low) sets count to one and free total to
// MEM_SIZE; the init state that follows writes entry zero as one hole
// covering the memory, during which in_ready stays low.
// A result waits in the output register while the receiver stalls; the
// next request is taken only once that word has left.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator_top #(
  parameter int MemSize     = ffsa_pkg::MemSize,
  parameter int MaxSegments = ffsa_pkg::MaxSegments
) (
  input wire logic clk,
  input wire logic rst_n,
  ffsa_req_if.sink   in_ch,
  ffsa_rsp_if.source out_ch
);
  localparam int IW = $clog2(MaxSegments);
  localparam int CW = IW + 1;
  localparam int SW = ffsa_pkg::SizeW;
  localparam int AW = ffsa_pkg::AddrW;
  localparam int EW = 1 + SW + AW;

  // Sequencer states.
  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2; // read issued for idx_r
  localparam logic [3:0] S_INS   = 4'd3; // shift tail up, write j+1
  localparam logic [3:0] S_INSW  = 4'd4; // read j
  localparam logic [3:0] S_NXT   = 4'd5; // read neighbor after hit
  localparam logic [3:0] S_PRV   = 4'd6; // read neighbor before hit
  localparam logic [3:0] S_REM   = 4'd7; // shift tail down, write j
  localparam logic [3:0] S_REMW  = 4'd8; // read j+1
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_PRVCK = 4'd10;

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] free_r, free_nxt;
  logic [CW-1:0] idx_r, idx_nxt;    // scan index / hit index
  logic [CW-1:0] j_r, j_nxt;        // shift cursor
  logic          kind_r, kind_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [EW-1:0] hit_r, hit_nxt;    // current (merged) hit entry, or the hole left by a split
  logic          prv_r, prv_nxt;    // pending check of previous neighbor
  logic [ffsa_pkg::StatusW-1:0] ost_r, ost_nxt;
  logic [AW-1:0] oad_r, oad_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [IW-1:0] wa, ra;
  logic [EW-1:0] wd, rd;

  ffsa_ram #(.Width(EW), .Depth(MaxSegments)) u_tab (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
  );

  logic          rd_use;
  logic [SW-1:0] rd_len, hit_len;
  logic [AW-1:0] rd_sta, hit_sta;
  assign rd_use  = rd[EW-1];
  assign rd_len  = rd[AW +: SW];
  assign rd_sta  = rd[AW-1:0];
  assign hit_len = hit_r[AW +: SW];
  assign hit_sta = hit_r[AW-1:0];

  logic [SW:0] left_w;
  assign left_w = {1'b0, rd_len} - {1'b0, size_r};

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; free_nxt = free_r; idx_nxt = idx_r;
    j_nxt = j_r; kind_nxt = kind_r; size_nxt = size_r;
    addr_nxt = addr_r; hit_nxt = hit_r; prv_nxt = prv_r; ost_nxt = ost_r;
    oad_nxt = oad_r; ov_nxt = ov_r;
    we = 1'b0; wa = idx_r[IW-1:0]; wd = hit_r; ra = idx_r[IW-1:0];
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (st_r)
      S_INIT: begin
        we = 1'b1; wa = '0;
        wd = {1'b0, SW'(MemSize), AW'(0)};
        st_nxt = S_IDLE;
      end
      S_IDLE: begin
        ra = '0;
        if (in_ch.valid && !ov_r) begin
          kind_nxt = in_ch.kind; size_nxt = in_ch.request_size;
          addr_nxt = in_ch.block_address; idx_nxt = '0; prv_nxt = 1'b0;
          oad_nxt = '0;
          if (in_ch.kind == ffsa_pkg::KIND_ALLOC && in_ch.request_size == '0) begin
            ost_nxt = ffsa_pkg::ST_NOFIT; st_nxt = S_DONE;
          end else begin
            st_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rd holds entry idx_r
        ra = IW'(idx_r + CW'(1));
        if (kind_r == ffsa_pkg::KIND_ALLOC) begin
          if (!rd_use && rd_len >= size_r) begin
            if (left_w != '0 && cnt_r == CW'(MaxSegments)) begin
              ost_nxt = ffsa_pkg::ST_FULL; st_nxt = S_DONE;
            end else begin
              we = 1'b1; wd = {1'b1, size_r, rd_sta};
              free_nxt = free_r - size_r;
              ost_nxt = ffsa_pkg::ST_GRANTED; oad_nxt = rd_sta;
              if (left_w != '0) begin
                hit_nxt = {1'b0, left_w[SW-1:0], AW'(rd_sta + size_r[AW-1:0])};
                j_nxt = cnt_r - CW'(1);
                cnt_nxt = cnt_r + CW'(1);
                st_nxt = S_INS; ra = IW'(cnt_r - CW'(1));
              end else begin
                st_nxt = S_DONE;
              end
            end
          end else if (idx_r + CW'(1) >= cnt_r) begin
            ost_nxt = ffsa_pkg::ST_NOFIT; st_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end else begin
          if (rd_use && rd_sta == addr_r) begin
            hit_nxt = {1'b0, rd_len, rd_sta};
            free_nxt = free_r + rd_len;
            ost_nxt = ffsa_pkg::ST_FREED;
            we = 1'b1; wd = {1'b0, rd_len, rd_sta};
            prv_nxt = (idx_r != '0);
            if (idx_r + CW'(1) < cnt_r) st_nxt = S_NXT;
            else st_nxt = S_PRVCK;
          end else if (idx_r + CW'(1) >= cnt_r) begin
            ost_nxt = ffsa_pkg::ST_UNKNOWN; st_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      S_INS: begin
        // rd holds entry j_r (issued previous cycle); j_r >= idx_r
        if (j_r == idx_r) begin
          we = 1'b1; wa = IW'(idx_r + CW'(1)); wd = hit_r; st_nxt = S_DONE;
        end else begin
          we = 1'b1; wa = IW'(j_r + CW'(1)); wd = rd;
          j_nxt = j_r - CW'(1); ra = IW'(j_r - CW'(1));
          st_nxt = S_INSW;
        end
      end
      S_INSW: begin
        ra = j_r[IW-1:0];
        st_nxt = S_INS;
      end
      S_NXT: begin
        // rd holds entry idx_r+1
        if (!rd_use) begin
          hit_nxt = {1'b0, SW'(hit_len + rd_len), hit_sta};
          we = 1'b1; wd = {1'b0, SW'(hit_len + rd_len), hit_sta};
          j_nxt = idx_r + CW'(1);
          ra = IW'(idx_r + CW'(2));
          st_nxt = S_REM;
        end else begin
          st_nxt = S_PRVCK;
        end
      end
      S_PRVCK: begin
        if (prv_r) begin
          ra = IW'(idx_r - CW'(1)); st_nxt = S_PRV;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_PRV: begin
        prv_nxt = 1'b0;
        if (!rd_use) begin
          we = 1'b1; wa = IW'(idx_r - CW'(1));
          wd = {1'b0, SW'(rd_len + hit_len), rd_sta};
          j_nxt = idx_r; ra = IW'(idx_r + CW'(1));
          st_nxt = S_REM;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_REM: begin
        // remove entry at cursor start; rd holds entry j_r+1
        if (j_r + CW'(1) >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt = S_PRVCK;
        end else begin
          we = 1'b1; wa = j_r[IW-1:0]; wd = rd;
          j_nxt = j_r + CW'(1);
          st_nxt = S_REMW;
        end
      end
      S_REMW: begin
        ra = IW'(j_r + CW'(1));
        st_nxt = S_REM;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; cnt_r <= CW'(1); free_r <= SW'(MemSize); ov_r <= 1'b0;
      prv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; free_r <= free_nxt; ov_r <= ov_nxt;
      prv_r <= prv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; j_r <= j_nxt; kind_r <= kind_nxt;
    size_r <= size_nxt; addr_r <= addr_nxt; hit_r <= hit_nxt;
    ost_r <= ost_nxt; oad_r <= oad_nxt;
  end

  assign in_ch.ready          = (st_r == S_IDLE) && !ov_r;
  assign out_ch.valid         = ov_r;
  assign out_ch.status        = ost_r;
  assign out_ch.start_address = oad_r;
  assign out_ch.free_total    = free_r;
endmodule
`default_nettype wire

// ----- rtl/ffsa_checker.sv -----
// Checker: port-level properties of the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [ffsa_pkg::StatusW-1:0] out_status,
  input wire logic [ffsa_pkg::AddrW-1:0]   out_start_address
);
  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffsa_pkg::ST_GRANTED |-> out_start_address == '0)
    else $error("address not zero");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ffsa_pkg::ST_FULL) else $error("bad status");
endmodule

bind first_fit_segment_allocator_top ffsa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
  .out_start_address(out_ch.start_address)
);
`default_nettype wire

// ----- tb/first_fit_segment_allocator_top_test.sv -----
// Testbench for the first-fit segment allocator: scoreboard class, drivers, checks.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: keeps a private copy of the segment table and predicts each result.
class alloc_scoreboard;
  localparam int NSeg = ffsa_pkg::MaxSegments;
  typedef struct packed {
    logic [ffsa_pkg::StatusW-1:0] status;
    logic [ffsa_pkg::AddrW-1:0]   start_address;
    logic [ffsa_pkg::SizeW-1:0]   free_total;
  } rsp_word_t;

  int unsigned seg_base[NSeg];
  int unsigned seg_len[NSeg];
  bit          seg_busy[NSeg];
  int unsigned seg_cnt;
  int unsigned free_amt;
  rsp_word_t   pending[$];
  int          errors;
  int          shown;

  function new();
    seg_base[0] = 0;
    seg_len[0]  = ffsa_pkg::MemSize;
    seg_busy[0] = 0;
    seg_cnt     = 1;
    free_amt    = ffsa_pkg::MemSize;
    errors      = 0;
    shown       = 0;
  endfunction

  function void drop_entry(int unsigned j);
    for (int unsigned k = j; k + 1 < seg_cnt; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_len[k]  = seg_len[k+1];
      seg_busy[k] = seg_busy[k+1];
    end
    seg_cnt--;
  endfunction

  function void grant(int unsigned size, output logic [2:0] st, output int unsigned addr);
    int unsigned left;
    st   = ffsa_pkg::ST_NOFIT;
    addr = 0;
    if (size == 0) return;
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      if (!seg_busy[i] && seg_len[i] >= size) begin
        left = seg_len[i] - size;
        if (left > 0 && seg_cnt >= NSeg) begin
          st = ffsa_pkg::ST_FULL;
          return;
        end
        seg_len[i]  = size;
        seg_busy[i] = 1;
        free_amt   -= size;
        if (left > 0) begin
          for (int unsigned k = seg_cnt; k > i + 1; k--) begin
            seg_base[k] = seg_base[k-1];
            seg_len[k]  = seg_len[k-1];
            seg_busy[k] = seg_busy[k-1];
          end
          seg_base[i+1] = seg_base[i] + size;
          seg_len[i+1]  = left;
          seg_busy[i+1] = 0;
          seg_cnt++;
        end
        addr = seg_base[i];
        st   = ffsa_pkg::ST_GRANTED;
        return;
      end
    end
  endfunction

  function logic [2:0] release_block(int unsigned address);
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      if (seg_busy[i] && seg_base[i] == address) begin
        seg_busy[i] = 0;
        free_amt   += seg_len[i];
        if (i + 1 < seg_cnt && !seg_busy[i+1]) begin
          seg_len[i] += seg_len[i+1];
          drop_entry(i + 1);
        end
        if (i > 0 && !seg_busy[i-1]) begin
          seg_len[i-1] += seg_len[i];
          drop_entry(i);
        end
        return ffsa_pkg::ST_FREED;
      end
    end
    return ffsa_pkg::ST_UNKNOWN;
  endfunction

  // Note an accepted request: predict and queue its result word.
  function void note_request(logic kind, logic [11:0] size, logic [10:0] address);
    rsp_word_t w;
    logic [2:0] st;
    int unsigned addr;
    addr = 0;
    if (kind == ffsa_pkg::KIND_ALLOC) grant(size, st, addr);
    else st = release_block(address);
    w.status        = st;
    w.start_address = addr[10:0];
    w.free_total    = free_amt[11:0];
    pending.push_back(w);
  endfunction

  // Pick an in-use start address, or a random one when nothing is in use.
  function logic [10:0] busy_address();
    int unsigned picks[$];
    for (int unsigned i = 0; i < seg_cnt; i++) if (seg_busy[i]) picks.push_back(seg_base[i]);
    if (picks.size() == 0) return 11'($urandom_range(0, 2047));
    return 11'(picks[$urandom_range(0, picks.size() - 1)]);
  endfunction

  function void check_result(logic [2:0] st, logic [10:0] addr, logic [11:0] ft);
    rsp_word_t w;
    if (pending.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected result word: status %0d addr %0d free %0d", st, addr, ft);
      end
      return;
    end
    w = pending.pop_front();
    if (w.status !== st || w.start_address !== addr || w.free_total !== ft) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch: expected status %0d addr %0d free %0d, got %0d %0d %0d",
                 w.status, w.start_address, w.free_total, st, addr, ft);
      end
    end
  endfunction
endclass

module first_fit_segment_allocator_top_test;
  logic clk;
  logic rst_n;

  ffsa_req_if in_ch();
  ffsa_rsp_if out_ch();

  first_fit_segment_allocator_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  alloc_scoreboard board = new();

  // Idle chance in percent; zero during the calm stretch.
  int  idle_pct = 16;
  bit  stim_done = 0;

  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    in_ch.valid         = 0;
    in_ch.kind          = ffsa_pkg::KIND_ALLOC;
    in_ch.request_size  = 0;
    in_ch.block_address = 0;
    out_ch.ready        = 0;
  end

  // Receiver: stall at random, check every word that moves.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.status, out_ch.start_address, out_ch.free_total);
    out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Send one request word; hold it until accepted, with random gaps first.
  task automatic send_word(logic kind, logic [11:0] size, logic [10:0] address);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid         <= 1;
    in_ch.kind          <= kind;
    in_ch.request_size  <= size;
    in_ch.block_address <= address;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Predict right after acceptance, in request order.
    board.note_request(kind, size, address);
  endtask

  task automatic pause_word();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic alloc_word(logic [11:0] size);
    send_word(ffsa_pkg::KIND_ALLOC, size, 11'($urandom_range(0, 2047)));
  endtask

  task automatic free_word(logic [10:0] address);
    send_word(ffsa_pkg::KIND_FREE, 12'($urandom_range(0, 4095)), address);
  endtask

  initial begin
    int kind_pick;
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // Directed: zero size, too large, exact fit of the whole memory, unknown
    // addresses (hole start and never-used), coalescing both sides.
    alloc_word(12'd0);
    alloc_word(12'd4095);
    alloc_word(12'd2049);
    alloc_word(12'd2048);
    alloc_word(12'd1);
    free_word(11'd0);
    free_word(11'd0);
    free_word(11'd2047);
    alloc_word(12'd100);
    alloc_word(12'd200);
    alloc_word(12'd300);
    free_word(11'd0);
    free_word(11'd300);
    free_word(11'd100);
    // Fill the table with unit blocks until a split is refused.
    for (int i = 0; i < 66; i++) alloc_word(12'd1);
    alloc_word(12'd2048);
    free_word(11'd5);
    alloc_word(12'd1);
    for (int i = 0; i < 66; i++) free_word(i[10:0]);

    // Random: mostly frees of live blocks and small allocations.
    for (int n = 0; n < 1300; n++) begin
      idle_pct = (n >= 400 && n < 600) ? 0 : 16;
      kind_pick = $urandom_range(0, 99);
      if (kind_pick < 45) alloc_word(12'($urandom_range(1, 64)));
      else if (kind_pick < 52) alloc_word(12'($urandom_range(0, 4095)));
      else if (kind_pick < 92) free_word(board.busy_address());
      else free_word(11'($urandom_range(0, 2047)));
    end
    idle_pct = 16;
    pause_word();
    stim_done = 1;
  end

  // End: drain expectations, then a latency tail.
  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #60ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
